@@ hw/rtl/eia_pkg.sv @@
`timescale 1ns / 1ps
// Package: sizes, register codes and shared types of the electrode impedance averager.
package eia_pkg;

   localparam int NUM_ELECTRODES = 23;
   localparam int WINDOW_LEN     = 50;
   localparam int NUM_CHANNELS   = NUM_ELECTRODES + 1;

   localparam int CH_W      = 5;
   localparam int SAMPLE_W  = 20;
   localparam int IMP_W     = 16;
   localparam int MAXIMP_W  = 14;
   localparam int SUM_W     = 26;
   localparam int FILL_W    = $clog2(WINDOW_LEN + 1);
   localparam int CHAN_AW   = $clog2(NUM_CHANNELS);
   localparam int SMP_DEPTH = NUM_CHANNELS * WINDOW_LEN;
   localparam int SMP_AW    = $clog2(SMP_DEPTH);
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_IMPEDANCE      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCONNECTED_VALUE = 1'd1;

   localparam logic [MAXIMP_W-1:0] MAX_IMPEDANCE_RESET      = 14'd4000;
   localparam logic [IMP_W-1:0]    DISCONNECTED_VALUE_RESET = 16'd16000;

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [FILL_W-1:0] fill;
      logic [FILL_W-1:0] slot;
   } chan_state_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [FILL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ hw/rtl/eia_if.sv @@
`timescale 1ns / 1ps
// Interfaces: sample item channel and impedance result channel.
interface eia_req_if;
   import eia_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CH_W-1:0]            channel;
   logic signed [SAMPLE_W-1:0] sample_value;
   modport source (output valid, output channel, output sample_value, input ready);
   modport sink   (input valid, input channel, input sample_value, output ready);
endinterface

interface eia_rsp_if;
   import eia_pkg::*;
   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  electrode;
   logic [IMP_W-1:0] impedance;
   logic             last;
   modport source (output valid, output electrode, output impedance, output last, input ready);
   modport sink   (input valid, input electrode, input impedance, input last, output ready);
endinterface

@@ hw/rtl/electrode_impedance_averager_top.sv @@
`timescale 1ns / 1ps
// Top level: neutral-referenced sliding-window impedance averager.
//
//   channel   direction  payload
//   req_item  in         channel, sample_value
//   rsp_item  out        electrode, impedance, last
//   csr_*     in         write enable, register index, write data
//
// An electrode item is accepted, then its state and sample are read, then written back.
// A neutral item then waits for the neutral division and handles each electrode in turn
// (state read, division start, 26 bit steps, result); an empty window skips the division.
// Reset is synchronous and clears the channel state valid bits at once.
// A stalled result holds the sequencer in its output step; inputs wait meanwhile.
module electrode_impedance_averager_top (
   input  logic                           clock,
   input  logic                           reset,
   eia_req_if.sink                        req_item,
   eia_rsp_if.source                      rsp_item,
   input  logic                           csr_write_en,
   input  logic [eia_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [eia_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import eia_pkg::*;

   typedef enum logic [6:0] {
      IDLE        = 7'b0000001,
      LOOKUP      = 7'b0000010,
      UPDATE      = 7'b0000100,
      NEUTRAL_DIV = 7'b0001000,
      ELEC_READ   = 7'b0010000,
      ELEC_CHECK  = 7'b0100000,
      EMIT        = 7'b1000000
   } state_type;

   // set while ELEC_CHECK waits on an electrode division
   state_type state_ff, state_in;
   logic      elec_div_ff, elec_div_in;

   logic [CHAN_AW-1:0]  ch_ff, ch_in;
   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   slot_ff, slot_in;
   logic [SMP_AW-1:0]   addr_ff, addr_in;
   logic [SUM_W-1:0]    neutral_ff, neutral_in;
   logic [SUM_W-1:0]    avg_ff, avg_in;
   logic [CHAN_AW-1:0]  elec_ff, elec_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]     rsp_electrode_ff, rsp_electrode_in;
   logic [IMP_W-1:0]    rsp_impedance_ff, rsp_impedance_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [MAXIMP_W-1:0] max_imp_ff;
   logic [IMP_W-1:0]    disc_ff;

   chan_state_type      chan_rd, chan_wr;
   logic                chan_we;
   logic [CHAN_AW-1:0]  chan_rd_addr;
   logic                smp_we;
   logic [SMP_AW-1:0]   smp_rd_addr;
   logic [SAMPLE_W-1:0] smp_rd_data;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic                ch_ok;
   logic [SAMPLE_W-1:0] req_mag;
   logic [FILL_W-1:0]   slot_fix;
   logic                full;
   logic [SUM_W-1:0]    sum_base, sum_new;
   logic [FILL_W-1:0]   fill_new, slot_next, slot_new;
   logic                out_free, is_last, disc_hit;
   logic [IMP_W-1:0]    imp;

   eia_chan_ram u_chan_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (chan_we),
      .wr_addr (ch_ff),
      .wr_data (chan_wr),
      .rd_addr (chan_rd_addr),
      .rd_data (chan_rd)
   );

   eia_sample_ram u_sample_ram (
      .clock   (clock),
      .wr_en   (smp_we),
      .wr_addr (addr_ff),
      .wr_data (mag_ff),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_rd_data)
   );

   eia_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_item.ready = (state_ff == IDLE);
   assign ch_ok   = req_item.channel <= CH_W'(NUM_ELECTRODES);
   assign req_mag = req_item.sample_value[SAMPLE_W-1]
                    ? SAMPLE_W'(~req_item.sample_value + 1'b1)
                    : SAMPLE_W'(req_item.sample_value);

   assign slot_fix    = (chan_rd.slot >= FILL_W'(WINDOW_LEN)) ? '0 : chan_rd.slot;
   assign smp_rd_addr = SMP_AW'(ch_ff) * SMP_AW'(WINDOW_LEN) + SMP_AW'(slot_fix);

   assign full      = fill_ff >= FILL_W'(WINDOW_LEN);
   assign sum_base  = full ? sum_ff - SUM_W'(smp_rd_data) : sum_ff;
   assign sum_new   = sum_base + SUM_W'(mag_ff);
   assign fill_new  = full ? fill_ff : FILL_W'(fill_ff + 1'b1);
   assign slot_next = FILL_W'(slot_ff + 1'b1);
   assign slot_new  = (slot_next >= FILL_W'(WINDOW_LEN)) ? '0 : slot_next;

   assign chan_wr.sum  = sum_new;
   assign chan_wr.fill = fill_new;
   assign chan_wr.slot = slot_new;

   assign out_free = !rsp_valid_ff || rsp_item.ready;
   assign is_last  = elec_ff == CHAN_AW'(NUM_ELECTRODES - 1);
   assign disc_hit = (avg_ff >= SUM_W'(max_imp_ff)) || (neutral_ff >= SUM_W'(max_imp_ff));
   assign imp      = disc_hit ? disc_ff
                   : (avg_ff > neutral_ff) ? IMP_W'(avg_ff - neutral_ff) : '0;

   always_comb begin
      state_in         = state_ff;
      elec_div_in      = elec_div_ff;
      ch_in            = ch_ff;
      mag_in           = mag_ff;
      sum_in           = sum_ff;
      fill_in          = fill_ff;
      slot_in          = slot_ff;
      addr_in          = addr_ff;
      neutral_in       = neutral_ff;
      avg_in           = avg_ff;
      elec_in          = elec_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_item.ready;
      rsp_electrode_in = rsp_electrode_ff;
      rsp_impedance_in = rsp_impedance_ff;
      rsp_last_in      = rsp_last_ff;
      chan_we          = 1'b0;
      smp_we           = 1'b0;
      chan_rd_addr     = '0;
      div_req          = '0;
      case (state_ff)
         IDLE: begin
            chan_rd_addr = ch_ok ? CHAN_AW'(req_item.channel) : '0;
            if (req_item.valid && ch_ok) begin
               ch_in    = CHAN_AW'(req_item.channel);
               mag_in   = req_mag;
               state_in = LOOKUP;
            end
         end
         LOOKUP: begin
            sum_in   = chan_rd.sum;
            fill_in  = chan_rd.fill;
            slot_in  = slot_fix;
            addr_in  = smp_rd_addr;
            state_in = UPDATE;
         end
         UPDATE: begin
            chan_we = 1'b1;
            smp_we  = 1'b1;
            if (ch_ff == CHAN_AW'(NUM_ELECTRODES)) begin
               div_req.start    = 1'b1;
               div_req.dividend = sum_new;
               div_req.divisor  = fill_new;
               state_in         = NEUTRAL_DIV;
            end else begin
               state_in = IDLE;
            end
         end
         NEUTRAL_DIV: begin
            if (div_rsp.done) begin
               neutral_in = div_rsp.quotient;
               elec_in    = '0;
               state_in   = ELEC_READ;
            end
         end
         ELEC_READ: begin
            chan_rd_addr = elec_ff;
            elec_div_in  = 1'b0;
            state_in     = ELEC_CHECK;
         end
         ELEC_CHECK: begin
            if (!elec_div_ff) begin
               if (chan_rd.fill == '0) begin
                  avg_in   = SUM_W'(max_imp_ff);
                  state_in = EMIT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = chan_rd.sum;
                  div_req.divisor  = chan_rd.fill;
                  elec_div_in      = 1'b1;
               end
            end else if (div_rsp.done) begin
               avg_in   = div_rsp.quotient;
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_electrode_in = CH_W'(elec_ff);
               rsp_impedance_in = imp;
               rsp_last_in      = is_last;
               if (is_last) begin
                  state_in = IDLE;
               end else begin
                  elec_in  = elec_ff + 1'b1;
                  state_in = ELEC_READ;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         elec_div_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_imp_ff   <= MAX_IMPEDANCE_RESET;
         disc_ff      <= DISCONNECTED_VALUE_RESET;
      end else begin
         state_ff     <= state_in;
         elec_div_ff  <= elec_div_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_MAX_IMPEDANCE:      max_imp_ff <= csr_write_data[MAXIMP_W-1:0];
               CSR_DISCONNECTED_VALUE: disc_ff    <= csr_write_data[IMP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff            <= ch_in;
      mag_ff           <= mag_in;
      sum_ff           <= sum_in;
      fill_ff          <= fill_in;
      slot_ff          <= slot_in;
      addr_ff          <= addr_in;
      neutral_ff       <= neutral_in;
      avg_ff           <= avg_in;
      elec_ff          <= elec_in;
      rsp_electrode_ff <= rsp_electrode_in;
      rsp_impedance_ff <= rsp_impedance_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_item.valid     = rsp_valid_ff;
   assign rsp_item.electrode = rsp_electrode_ff;
   assign rsp_item.impedance = rsp_impedance_ff;
   assign rsp_item.last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("division started while divider busy");
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> (elec_ff < CHAN_AW'(NUM_ELECTRODES)))
      else $error("electrode counter out of range");
   a_last_electrode: assert property (@(posedge clock) disable iff (reset)
      (rsp_item.valid && rsp_item.last) |-> (rsp_item.electrode == CH_W'(NUM_ELECTRODES - 1)))
      else $error("last flag on wrong electrode");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LOOKUP) |-> (chan_rd.fill <= FILL_W'(WINDOW_LEN)))
      else $error("fill count beyond window length");
   a_update_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == UPDATE) |-> ($past(state_ff) == LOOKUP))
      else $error("write back without state lookup");
`endif

endmodule

@@ hw/rtl/eia_sample_ram.sv @@
`timescale 1ns / 1ps
// Sample store: one write port, one registered read port, contents undefined until written.
module eia_sample_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [eia_pkg::SMP_AW-1:0]   wr_addr,
   input  logic [eia_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [eia_pkg::SMP_AW-1:0]   rd_addr,
   output logic [eia_pkg::SAMPLE_W-1:0] rd_data
);
   import eia_pkg::*;

   logic [SAMPLE_W-1:0] mem [SMP_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/eia_chan_ram.sv @@
`timescale 1ns / 1ps
// Per-channel window state memory with valid bits; an unwritten entry reads as zero.
module eia_chan_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [eia_pkg::CHAN_AW-1:0] wr_addr,
   input  eia_pkg::chan_state_type     wr_data,
   input  logic [eia_pkg::CHAN_AW-1:0] rd_addr,
   output eia_pkg::chan_state_type     rd_data
);
   import eia_pkg::*;

   chan_state_type          mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   chan_state_type          rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ hw/rtl/eia_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider: window sum by sample count, one quotient bit per cycle.
module eia_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  eia_pkg::div_req_type div_req,
   output eia_pkg::div_rsp_type div_rsp
);
   import eia_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [FILL_W-1:0]    rem_ff, rem_in;
   logic [FILL_W-1:0]    div_ff, div_in;
   logic [FILL_W:0]      trial;
   logic                 fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      fits     = trial >= {1'b0, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(SUM_W - 1);
         quo_in   = div_req.dividend;
         rem_in   = '0;
         div_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? FILL_W'(trial - {1'b0, div_ff}) : FILL_W'(trial);
         quo_in = {quo_ff[SUM_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a division in progress");
`endif

endmodule

@@ tb/sv/tb_electrode_impedance_averager_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the impedance averager, with a window-average predictor.
module tb_electrode_impedance_averager_top;
   import eia_pkg::*;

   localparam int NEUTRAL_CHANNEL = NUM_ELECTRODES;
   localparam int HOT_ELECTRODE   = 0;
   localparam int DRAIN_CYCLES    = 1000;
   localparam int WATCHDOG_LIMIT  = 20000;

   typedef struct packed {
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample_value;
   } sample_item_type;

   typedef struct packed {
      logic [CH_W-1:0]  electrode;
      logic [IMP_W-1:0] impedance;
      logic             last;
   } impedance_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   eia_req_if req_bus ();
   eia_rsp_if rsp_bus ();

   electrode_impedance_averager_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_item       (req_bus),
      .rsp_item       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // predictor state
   logic [SAMPLE_W-1:0] mag_store [NUM_CHANNELS][WINDOW_LEN];
   logic [SUM_W-1:0]    win_total [NUM_CHANNELS];
   int unsigned         win_fill  [NUM_CHANNELS];
   int unsigned         win_slot  [NUM_CHANNELS];
   logic [MAXIMP_W-1:0] thresh;
   logic [IMP_W-1:0]    disc_value;

   sample_item_type      sample_pending [$];
   impedance_result_type impedance_expected [$];

   int unsigned          items_issued;
   int unsigned          items_accepted;
   int unsigned          error_count;
   int unsigned          stuck_cycles;
   int unsigned          req_gap;
   int unsigned          rsp_stall;
   bit                   idling_on;
   sample_item_type      next_sample;
   impedance_result_type seen;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned window_mean(int unsigned ch);
      if (win_fill[ch] == 0) return 32'(thresh);
      return win_total[ch] / win_fill[ch];
   endfunction

   function automatic void predict_impedances(logic [CH_W-1:0] channel,
                                              logic [SAMPLE_W-1:0] raw);
      int unsigned          ch;
      int unsigned          mag;
      int unsigned          ref_mean;
      int unsigned          mean;
      impedance_result_type res;
      ch = channel;
      if (ch > NUM_ELECTRODES) return;
      mag = raw[SAMPLE_W-1] ? (32'h100000 - {12'd0, raw}) : {12'd0, raw};
      if (win_fill[ch] >= WINDOW_LEN)
         win_total[ch] = win_total[ch] - mag_store[ch][win_slot[ch]];
      else
         win_fill[ch] = win_fill[ch] + 1;
      mag_store[ch][win_slot[ch]] = SAMPLE_W'(mag);
      win_total[ch] = win_total[ch] + SUM_W'(mag);
      win_slot[ch] = (win_slot[ch] + 1 >= WINDOW_LEN) ? 0 : win_slot[ch] + 1;
      if (ch != NEUTRAL_CHANNEL) return;
      ref_mean = window_mean(NEUTRAL_CHANNEL);
      for (int e = 0; e < NUM_ELECTRODES; e++) begin
         mean = window_mean(e);
         if (mean >= thresh || ref_mean >= thresh)
            res.impedance = disc_value;
         else
            res.impedance = (mean > ref_mean) ? IMP_W'(mean - ref_mean) : '0;
         res.electrode = CH_W'(e);
         res.last      = (e == NUM_ELECTRODES - 1);
         impedance_expected.push_back(res);
      end
   endfunction

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_MAX_IMPEDANCE)
         thresh = value[MAXIMP_W-1:0];
      else if (idx == CSR_DISCONNECTED_VALUE)
         disc_value = value;
   endtask

   task automatic add_item(int unsigned channel, int value);
      sample_item_type it;
      it.channel      = CH_W'(channel);
      it.sample_value = SAMPLE_W'(value);
      sample_pending.push_back(it);
      items_issued++;
   endtask

   task automatic add_random_items(int unsigned count);
      int unsigned counted;
      int unsigned pick;
      int unsigned ch;
      int          value;
      counted = 0;
      while (counted < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 28)      ch = NEUTRAL_CHANNEL;
         else if (pick < 62) ch = HOT_ELECTRODE;
         else if (pick < 67) ch = 1;
         else if (pick < 92) ch = $urandom_range(0, NUM_ELECTRODES - 1);
         else                ch = $urandom_range(NUM_CHANNELS, 31);
         pick = $urandom_range(0, 99);
         if (pick < 96) begin
            value = $urandom_range(0, int'(thresh) + int'(thresh) / 4 + 8);
            if ($urandom_range(0, 1) != 0) value = -value;
         end else if (pick < 98) begin
            value = $urandom;
         end else begin
            case ($urandom_range(0, 5))
               0:       value = 1;
               1:       value = -1;
               2:       value = 524287;
               3:       value = -524288;
               4:       value = int'(thresh) - 1;
               default: value = int'(thresh);
            endcase
         end
         add_item(ch, value);
         if (ch <= NUM_ELECTRODES) counted++;
      end
   endtask

   task automatic wait_for_idle();
      while (items_accepted != items_issued) @(posedge clock);
      while (impedance_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sample item driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.channel      <= '0;
         req_bus.sample_value <= '0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_impedances(req_bus.channel, req_bus.sample_value);
            items_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (sample_pending.size() != 0) begin
               next_sample = sample_pending.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.channel      <= next_sample.channel;
               req_bus.sample_value <= next_sample.sample_value;
               if (idling_on && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 8);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.electrode = rsp_bus.electrode;
            seen.impedance = rsp_bus.impedance;
            seen.last      = rsp_bus.last;
            if (impedance_expected.size() == 0) begin
               error_count++;
               $display("%0t: expected none, actual electrode %0d impedance %0d last %0b",
                        $time, seen.electrode, seen.impedance, seen.last);
            end else if (seen.electrode !== impedance_expected[0].electrode ||
                         seen.impedance !== impedance_expected[0].impedance ||
                         seen.last !== impedance_expected[0].last) begin
               error_count++;
               $display("%0t: expected e%0d imp %0d last %0b, actual e%0d imp %0d last %0b",
                        $time, impedance_expected[0].electrode,
                        impedance_expected[0].impedance, impedance_expected[0].last,
                        seen.electrode, seen.impedance, seen.last);
            end
            if (impedance_expected.size() != 0) void'(impedance_expected.pop_front());
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 9) == 0) rsp_stall = $urandom_range(1, 8);
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         stuck_cycles <= 0;
      else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_write_en         = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;
      items_issued         = 0;
      items_accepted       = 0;
      error_count          = 0;
      idling_on            = 1'b1;
      thresh               = MAX_IMPEDANCE_RESET;
      disc_value           = DISCONNECTED_VALUE_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         win_total[c] = '0;
         win_fill[c]  = 0;
         win_slot[c]  = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty windows, ignored channels, extremes, flooring, threshold edges
      write_register(CSR_MAX_IMPEDANCE, 16'd4000);
      write_register(CSR_DISCONNECTED_VALUE, 16'd16000);
      add_item(NEUTRAL_CHANNEL, 10);
      add_item(NUM_CHANNELS, 123);
      add_item(31, -1);
      add_item(1, 0);
      add_item(2, -1);
      add_item(3, 3999);
      add_item(4, -4000);
      add_item(5, 100);
      add_item(NUM_ELECTRODES - 1, -37);
      add_item(NEUTRAL_CHANNEL, 0);
      add_item(1, 7);
      add_item(HOT_ELECTRODE, 524287);
      add_item(HOT_ELECTRODE, -524288);
      add_item(6, -2);
      add_item(7, 4003);
      add_item(8, 13);
      add_item(NEUTRAL_CHANNEL, -30);
      add_item(3, 4002);
      add_item(8, 15);
      add_item(NEUTRAL_CHANNEL, 16);
      wait_for_idle();

      // upper bits beyond the threshold width are dropped
      write_register(CSR_MAX_IMPEDANCE, 16'hFFFF);
      write_register(CSR_DISCONNECTED_VALUE, 16'd0);
      add_random_items(50);
      wait_for_idle();

      write_register(CSR_MAX_IMPEDANCE, 16'd0);
      write_register(CSR_DISCONNECTED_VALUE, 16'hFFFF);
      add_random_items(20);
      wait_for_idle();

      write_register(CSR_MAX_IMPEDANCE, CSR_DATA_W'($urandom_range(1500, 3500)));
      write_register(CSR_DISCONNECTED_VALUE, CSR_DATA_W'($urandom));
      add_random_items(60);
      wait_for_idle();

      idling_on = 1'b0;
      write_register(CSR_MAX_IMPEDANCE, 16'd4000);
      write_register(CSR_DISCONNECTED_VALUE, 16'd16000);
      add_random_items(60);
      wait_for_idle();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
